// ----- rtl/device_quorum_watchdog_assert.svh -----
// Assertion macros for the device quorum watchdog.
`ifndef DEVICE_QUORUM_WATCHDOG_ASSERT_SVH
`define DEVICE_QUORUM_WATCHDOG_ASSERT_SVH

`ifndef SYNTH
`define DQW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define DQW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DQW_ASSERT(label, clk, rst_n, prop, msg)
`define DQW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/dqw_pkg.sv -----
`default_nettype none

package dqw_pkg;

    localparam int NUM_DEVICES_DEF = 5;
    localparam int NUM_DEVICES_MAX = 16;

    localparam int OFF_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  ID_BASE_RST       = 8'hE7;
    localparam logic [7:0]  TOKEN_FIRST_RST   = 8'h00;
    localparam logic [7:0]  TOKEN_SECOND_RST  = 8'hAA;
    localparam logic [15:0] WINDOW_TICKS_RST  = 16'd2000;
    localparam logic [4:0]  OFF_THRESHOLD_RST = 5'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ID_BASE       = 3'd0,
        CFG_TOKEN_FIRST   = 3'd1,
        CFG_TOKEN_SECOND  = 3'd2,
        CFG_WINDOW_TICKS  = 3'd3,
        CFG_OFF_THRESHOLD = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OUT_TICK      = 2'd0,
        OUT_ACCEPT    = 2'd1,
        OUT_BAD_TOKEN = 2'd2,
        OUT_UNKNOWN   = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [7:0]  id_base;
        logic [7:0]  token_first;
        logic [7:0]  token_second;
        logic [15:0] window_ticks;
        logic [4:0]  off_threshold;
    } t_cfg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] token_first_req;
        logic [7:0] token_second_req;
        logic [7:0] device_id;
        logic [7:0] status_value;
    } t_item;

    typedef struct packed {
        logic             control_level;
        t_outcome         packet_outcome;
        logic             window_end;
        logic             window_tripped;
        logic [OFF_W-1:0] off_count;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/dqw_cfg.sv -----
`default_nettype none

module dqw_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_we,
    input  wire logic [dqw_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [dqw_pkg::CFG_DATA_W-1:0] i_data,
    output dqw_pkg::t_cfg                        o_cfg
);
    import dqw_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                CFG_ID_BASE:       n_cfg.id_base       = i_data[7:0];
                CFG_TOKEN_FIRST:   n_cfg.token_first   = i_data[7:0];
                CFG_TOKEN_SECOND:  n_cfg.token_second  = i_data[7:0];
                CFG_WINDOW_TICKS:  n_cfg.window_ticks  = i_data[15:0];
                CFG_OFF_THRESHOLD: n_cfg.off_threshold = i_data[4:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.id_base       <= ID_BASE_RST;
            r_cfg.token_first   <= TOKEN_FIRST_RST;
            r_cfg.token_second  <= TOKEN_SECOND_RST;
            r_cfg.window_ticks  <= WINDOW_TICKS_RST;
            r_cfg.off_threshold <= OFF_THRESHOLD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/dqw_core.sv -----
`default_nettype none

`include "device_quorum_watchdog_assert.svh"

module dqw_core #(
    parameter int NUM_DEVICES = dqw_pkg::NUM_DEVICES_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire dqw_pkg::t_cfg    i_cfg,
    input  wire logic    i_vld,
    input  wire dqw_pkg::t_item   i_item,
    output logic         o_ready,
    input  wire logic    i_out_stall,
    output logic         o_vld,
    output dqw_pkg::t_result o_res
);
    import dqw_pkg::*;

    localparam logic [7:0] DEV_CNT = 8'(NUM_DEVICES);

    logic [NUM_DEVICES-1:0] r_off;
    logic [NUM_DEVICES-1:0] n_off;
    logic [15:0]            r_tick;
    logic [15:0]            n_tick;
    logic                   r_run;
    logic                   n_run;
    logic                   r_level;
    logic                   n_level;
    logic                   r_out_vld;
    t_result                r_res;
    t_result                n_res;

    logic                   fire;
    logic [7:0]             slot;
    logic [15:0]            tick_inc;
    logic [OFF_W-1:0]       cnt_cur;
    logic [OFF_W-1:0]       cnt_next;

    assign o_ready = !r_out_vld || !i_out_stall;
    assign fire    = i_vld && o_ready;
    assign slot    = i_item.device_id - i_cfg.id_base;
    assign tick_inc = r_tick + 16'd1;

    always_comb begin
        cnt_cur = '0;
        for (int i = 0; i < NUM_DEVICES; i++) begin
            cnt_cur = cnt_cur + OFF_W'(r_off[i]);
        end
    end

    always_comb begin
        n_off   = r_off;
        n_tick  = r_tick;
        n_run   = r_run;
        n_level = r_level;
        n_res.packet_outcome = OUT_TICK;
        n_res.window_end     = 1'b0;
        n_res.window_tripped = 1'b0;
        if (!i_item.req_type) begin
            if (i_item.token_first_req != i_cfg.token_first ||
                i_item.token_second_req != i_cfg.token_second) begin
                n_res.packet_outcome = OUT_BAD_TOKEN;
            end else if (slot >= DEV_CNT) begin
                n_res.packet_outcome = OUT_UNKNOWN;
            end else begin
                n_res.packet_outcome = OUT_ACCEPT;
                for (int i = 0; i < NUM_DEVICES; i++) begin
                    if (slot == 8'(i)) begin
                        n_off[i] = (i_item.status_value == 8'd0);
                    end
                end
            end
        end else if (r_run) begin
            n_tick = tick_inc;
            if (tick_inc == i_cfg.window_ticks) begin
                n_res.window_end = 1'b1;
                n_tick = '0;
                if (cnt_cur >= i_cfg.off_threshold) begin
                    n_res.window_tripped = 1'b1;
                    n_level = 1'b0;
                    n_run   = 1'b0;
                end else begin
                    n_off = '0;
                end
            end
        end
        n_res.control_level = n_level;
        n_res.off_count     = cnt_next;
    end

    always_comb begin
        cnt_next = '0;
        for (int i = 0; i < NUM_DEVICES; i++) begin
            cnt_next = cnt_next + OFF_W'(n_off[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off     <= '0;
            r_tick    <= '0;
            r_run     <= 1'b1;
            r_level   <= 1'b1;
            r_out_vld <= 1'b0;
        end else begin
            if (fire) begin
                r_off   <= n_off;
                r_tick  <= n_tick;
                r_run   <= n_run;
                r_level <= n_level;
            end
            if (o_ready) begin
                r_out_vld <= i_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_res;

    `DQW_ASSERT(a_latch_holds, i_clk, i_rst_n, !r_level |=> !r_level, "control latch released")
    `DQW_ASSERT(a_run_tracks_level, i_clk, i_rst_n, r_run == r_level, "run and level disagree")
    `DQW_ASSERT_IMP(a_stopped_idle, i_clk, i_rst_n, !r_run, r_tick == '0, "tick count moved while stopped")
    `DQW_ASSERT_IMP(a_trip_result, i_clk, i_rst_n, r_out_vld && r_res.window_tripped, !r_res.control_level && r_res.window_end, "trip result inconsistent")

endmodule

`default_nettype wire

// ----- rtl/device_quorum_watchdog.sv -----
// Path: an accepted item goes into the input register, then its result into the result
// register. Throughput: one item per cycle while the output is not stalled;
// the state update is a single pass over the flags.
// Reset (synchronous, active low): registers to defaults, all devices on, count zero,
// window running, control output on, both pipeline stages empty.
`default_nettype none

module device_quorum_watchdog #(
    parameter int NUM_DEVICES = dqw_pkg::NUM_DEVICES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dqw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dqw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_req_type,
    input  wire logic [7:0]                      i_token_first_req,
    input  wire logic [7:0]                      i_token_second_req,
    input  wire logic [7:0]                      i_device_id,
    input  wire logic [7:0]                      i_status_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_control_level,
    output logic [1:0]                           o_packet_outcome,
    output logic                                 o_window_end,
    output logic                                 o_window_tripped,
    output logic [dqw_pkg::OFF_W-1:0]            o_off_count
);
    import dqw_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_vld;
    logic    core_ready;
    t_result res;

    dqw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign o_in_stall = r_in_vld && !core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in.req_type         <= i_req_type;
            r_in.token_first_req  <= i_token_first_req;
            r_in.token_second_req <= i_token_second_req;
            r_in.device_id        <= i_device_id;
            r_in.status_value     <= i_status_value;
        end
    end

    dqw_core #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_vld       (r_in_vld),
        .i_item      (r_in),
        .o_ready     (core_ready),
        .i_out_stall (i_out_stall),
        .o_vld       (o_out_valid),
        .o_res       (res)
    );

    assign o_control_level  = res.control_level;
    assign o_packet_outcome = res.packet_outcome;
    assign o_window_end     = res.window_end;
    assign o_window_tripped = res.window_tripped;
    assign o_off_count      = res.off_count;

endmodule

`default_nettype wire
